// ----- design/spse_pkg.sv -----
// Shared types and constants for the spoke period speed estimator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package spse_pkg;

  localparam int TIME_BITS     = 32;
  localparam int SPEED_BITS    = 16;
  localparam int DIST_BITS     = 13;
  localparam int CIRC_BITS     = 10;
  localparam int LIMIT_BITS    = 16;
  localparam int COUNT_BITS    = 32;
  localparam int DIVIDEND_BITS = 24;
  localparam int CMS_BITS      = 20;
  localparam int PROD_BITS     = LIMIT_BITS + TIME_BITS;
  localparam int DIV_STEPS     = DIVIDEND_BITS;
  localparam int STEP_BITS     = $clog2(DIV_STEPS);
  localparam int ADDR_BITS     = 4;
  localparam int DATA_BITS     = 32;

  localparam logic [DIST_BITS-1:0]     ThresholdReset = DIST_BITS'(110);
  localparam logic [CIRC_BITS-1:0]     CircReset      = CIRC_BITS'(10);
  localparam logic [LIMIT_BITS-1:0]    LimitReset     = LIMIT_BITS'(40);
  localparam logic [DIVIDEND_BITS-1:0] TenthsScale    = DIVIDEND_BITS'(10000);
  localparam logic [CMS_BITS-1:0]      CmsScale       = CMS_BITS'(1000);
  localparam logic [SPEED_BITS-1:0]    SpeedMax       = {SPEED_BITS{1'b1}};
  localparam logic [STEP_BITS-1:0]     LastStep       = STEP_BITS'(DIV_STEPS - 1);

  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_CIRC      = 2'd1,
    REG_LIMIT     = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [DIST_BITS-1:0]  threshold;
    logic [CIRC_BITS-1:0]  circ;
    logic [LIMIT_BITS-1:0] limit;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic mult;
    logic div_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic div_last;
  } status_t;

endpackage

// ----- design/spse_cfg.sv -----
// Configuration register file behind an APB-style slave port.
// Depends on spse_pkg for widths, reset values and register indexes.
`timescale 1ns / 1ps

module spse_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [spse_pkg::ADDR_BITS-1:0] paddr,
  input  logic [spse_pkg::DATA_BITS-1:0] pwdata,
  output logic [spse_pkg::DATA_BITS-1:0] prdata,
  output logic                          pready,
  output spse_pkg::cfg_t                cfg_o
);
  import spse_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_THRESHOLD: cfg_d.threshold = pwdata[DIST_BITS-1:0];
        REG_CIRC:      cfg_d.circ      = pwdata[CIRC_BITS-1:0];
        REG_LIMIT:     cfg_d.limit     = pwdata[LIMIT_BITS-1:0];
        default:       cfg_d           = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_THRESHOLD: prdata = DATA_BITS'(cfg_q.threshold);
      REG_CIRC:      prdata = DATA_BITS'(cfg_q.circ);
      REG_LIMIT:     prdata = DATA_BITS'(cfg_q.limit);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold <= ThresholdReset;
      cfg_q.circ      <= CircReset;
      cfg_q.limit     <= LimitReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ----- design/spse_ctrl.sv -----
// Sequencer for one sample: accept, prepare, multiply, divide, deliver.
// Depends on spse_pkg for the command and status structs.
`timescale 1ns / 1ps

module spse_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  spse_pkg::status_t status_i,
  output spse_pkg::cmd_t    cmd_o
);
  import spse_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MULT,
    ST_DIV,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = ST_MULT;
      end
      ST_MULT: begin
        cmd_o.mult = 1'b1;
        state_d    = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- design/spse_dp.sv -----
// Datapath: spoke tracking state, period, limit product, radix-2 divider
// and output register. Depends on spse_pkg; driven by spse_ctrl commands.
`timescale 1ns / 1ps

module spse_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  spse_pkg::cfg_t                    cfg_i,
  input  spse_pkg::cmd_t                    cmd_i,
  output spse_pkg::status_t                 status_o,
  input  logic [spse_pkg::DIST_BITS-1:0]    distance_mm_i,
  input  logic [spse_pkg::TIME_BITS-1:0]    now_ms_i,
  output logic [spse_pkg::SPEED_BITS-1:0]   speed_tenths_o,
  output logic                              overspeed_o,
  output logic                              spoke_event_o,
  output logic [spse_pkg::COUNT_BITS-1:0]   spoke_total_o
);
  import spse_pkg::*;

  // spoke state
  logic                  tracking_q;
  logic [TIME_BITS-1:0]  last_q, prior_q;
  logic [COUNT_BITS-1:0] count_q;
  logic                  hit, clear;

  // per-sample working registers
  logic [TIME_BITS-1:0]     now_q, period_q;
  logic                     event_q, no_speed_q, period_zero_q;
  logic [CMS_BITS-1:0]      cms_q;
  logic [PROD_BITS-1:0]     prod_q;
  logic [TIME_BITS-1:0]     rem_q;
  logic [DIVIDEND_BITS-1:0] quot_q;
  logic [STEP_BITS-1:0]     step_q;

  // output register
  logic [SPEED_BITS-1:0] speed_q;
  logic                  over_q, spoke_q;
  logic [COUNT_BITS-1:0] total_q;

  logic [TIME_BITS-1:0] since, gap;
  logic [TIME_BITS:0]   trial, diff;
  logic [SPEED_BITS-1:0] speed_sat;
  logic                 over_cmp;

  assign hit   = (distance_mm_i < cfg_i.threshold) && !tracking_q;
  assign clear = distance_mm_i > cfg_i.threshold;

  assign since = now_q - last_q;
  assign gap   = last_q - prior_q;

  assign trial = {rem_q, quot_q[DIVIDEND_BITS-1]};
  assign diff  = trial - {1'b0, period_q};

  assign speed_sat = (quot_q[DIVIDEND_BITS-1:SPEED_BITS] != '0) ? SpeedMax
                   : quot_q[SPEED_BITS-1:0];
  assign over_cmp  = prod_q < PROD_BITS'(cms_q);

  assign status_o.div_last = (step_q == LastStep);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tracking_q <= 1'b0;
      last_q     <= '0;
      prior_q    <= '0;
      count_q    <= '0;
    end else if (cmd_i.load) begin
      if (hit) begin
        tracking_q <= 1'b1;
        prior_q    <= last_q;
        last_q     <= now_ms_i;
        count_q    <= count_q + 1'b1;
      end else if (clear) begin
        tracking_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      now_q   <= now_ms_i;
      event_q <= hit;
    end
    if (cmd_i.prep) begin
      period_q      <= (since > gap) ? since : gap;
      period_zero_q <= (since == '0) && (gap == '0);
      no_speed_q    <= (count_q == '0) || (cfg_i.circ == '0);
      cms_q         <= CMS_BITS'(cfg_i.circ) * CmsScale;
      quot_q        <= DIVIDEND_BITS'(cfg_i.circ) * TenthsScale;
      rem_q         <= '0;
      step_q        <= '0;
    end
    if (cmd_i.mult) begin
      prod_q <= {{TIME_BITS{1'b0}}, cfg_i.limit} * {{LIMIT_BITS{1'b0}}, period_q};
    end
    if (cmd_i.div_step) begin
      if (!diff[TIME_BITS]) begin
        rem_q  <= diff[TIME_BITS-1:0];
        quot_q <= {quot_q[DIVIDEND_BITS-2:0], 1'b1};
      end else begin
        rem_q  <= trial[TIME_BITS-1:0];
        quot_q <= {quot_q[DIVIDEND_BITS-2:0], 1'b0};
      end
      step_q <= step_q + 1'b1;
    end
    if (cmd_i.finish) begin
      spoke_q <= event_q;
      total_q <= count_q;
      if (no_speed_q) begin
        speed_q <= '0;
        over_q  <= 1'b0;
      end else if (period_zero_q) begin
        speed_q <= SpeedMax;
        over_q  <= 1'b1;
      end else begin
        speed_q <= speed_sat;
        over_q  <= over_cmp;
      end
    end
  end

  assign speed_tenths_o = speed_q;
  assign overspeed_o    = over_q;
  assign spoke_event_o  = spoke_q;
  assign spoke_total_o  = total_q;

endmodule

// ----- design/spoke_period_speed_estimator_core.sv -----
// Spoke period speed estimator: input channel takes one distance sample with
// its millisecond timestamp, output channel returns one result per sample.
// A sample is accepted when in_valid_i is high and in_stall_o is low; a
// result is taken when out_valid_o is high and out_stall_i is low.
// Each result carries speed in tenths of cm/s (saturating), an overspeed
// flag, a flag for a newly detected spoke and the running spoke count.
// A sample passes the prepare and multiply steps and the 24-step radix-2
// divider, which forms circumference*10000 / period one quotient bit a cycle;
// input stays stalled until its result is delivered to the output register.
// A new sample is taken while the previous result still waits in the output
// register; if the receiver stalls, the next result waits in the sequencer
// and input stays stalled until the output register frees up.
// Reset clears the spoke state and count and returns the threshold (110 mm),
// circumference (10 cm) and overspeed limit (40 cm/s) to their defaults.
// Registers sit on the APB port at 0x0, 0x4 and 0x8; write only when idle.
// Depends on spse_pkg, spse_cfg, spse_ctrl and spse_dp.
`timescale 1ns / 1ps

module spoke_period_speed_estimator_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [spse_pkg::DIST_BITS-1:0]    distance_mm_i,
  input  logic [spse_pkg::TIME_BITS-1:0]    now_ms_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [spse_pkg::SPEED_BITS-1:0]   speed_tenths_o,
  output logic                              overspeed_o,
  output logic                              spoke_event_o,
  output logic [spse_pkg::COUNT_BITS-1:0]   spoke_total_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [spse_pkg::ADDR_BITS-1:0]    paddr,
  input  logic [spse_pkg::DATA_BITS-1:0]    pwdata,
  output logic [spse_pkg::DATA_BITS-1:0]    prdata,
  output logic                              pready
);
  import spse_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  spse_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  spse_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  spse_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .cmd_i          (cmd),
    .status_o       (status),
    .distance_mm_i  (distance_mm_i),
    .now_ms_i       (now_ms_i),
    .speed_tenths_o (speed_tenths_o),
    .overspeed_o    (overspeed_o),
    .spoke_event_o  (spoke_event_o),
    .spoke_total_o  (spoke_total_o)
  );

endmodule

// ----- design/spse_checker.sv -----
// Port-level checks for the spoke period speed estimator, bound to the top.
// Depends on spse_pkg for port widths.
`timescale 1ns / 1ps

module spse_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic [spse_pkg::DIST_BITS-1:0]    distance_mm_i,
  input logic [spse_pkg::TIME_BITS-1:0]    now_ms_i,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic [spse_pkg::SPEED_BITS-1:0]   speed_tenths_o,
  input logic                              overspeed_o,
  input logic                              spoke_event_o,
  input logic [spse_pkg::COUNT_BITS-1:0]   spoke_total_o,
  input logic                              psel,
  input logic                              penable,
  input logic                              pwrite,
  input logic [spse_pkg::ADDR_BITS-1:0]    paddr,
  input logic [spse_pkg::DATA_BITS-1:0]    pwdata,
  input logic [spse_pkg::DATA_BITS-1:0]    prdata,
  input logic                              pready
);
  import spse_pkg::*;

  // one sample in flight: an accepted beat blocks the next one
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while a sample is in flight");

  // no speed before the first counted spoke
  a_no_speed_at_zero_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (spoke_total_o == '0) |-> (speed_tenths_o == '0) && !overspeed_o)
    else $error("speed reported with zero spoke count");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(speed_tenths_o)
      && $stable(overspeed_o) && $stable(spoke_event_o) && $stable(spoke_total_o))
    else $error("stalled result beat changed");

  // the block never keeps the APB port waiting
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel |-> pready)
    else $error("pready low during access");

endmodule

bind spoke_period_speed_estimator_core spse_checker u_spse_checker (.*);
